### rtl/bhtp_pkg.sv
package bhtp_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 32;
   localparam int HISTORY_BITS  = 4;
   localparam int INDEX_BITS    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // field widths
   localparam int ADDR_BITS  = 32;
   localparam int COUNT_BITS = 32;

   // prediction loaded into the table after reset
   localparam logic INIT_PREDICTION_RESET = 1'b1;

   typedef logic [INDEX_BITS-1:0]   index_type;
   typedef logic [HISTORY_BITS-1:0] history_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   // one resolved branch going into the table
   typedef struct packed {
      logic      valid;
      index_type index;
      logic      taken;
   } update_type;

   // bulk load of every prediction bit
   typedef struct packed {
      logic en;
      logic value;
   } fill_type;

   // counter update and the totals that include it
   typedef struct packed {
      logic valid;
      logic hit;
   } tally_type;

   typedef struct packed {
      count_type correct;
      count_type wrong;
   } totals_type;

endpackage

### rtl/branch_history_table_predictor_unit.sv
// path: an accepted beat is captured in the input register, then its result in the result register, shown for one cycle
// throughput: one beat per cycle; busy stays low, the table update is a read-modify-write
//   of flip-flop entries between the input and result registers
// the receiver cannot stall; rsp_valid strobes for exactly one cycle per beat
// reset (synchronous, active high): predictions to taken, histories and totals to zero,
//   initial prediction register to taken
module branch_history_table_predictor_unit
   import bhtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_BITS-1:0]  req_branch_address,
   input  logic                  req_taken,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_initial_prediction,
   output logic                  rsp_valid,
   output logic                  rsp_predicted_taken,
   output logic                  rsp_prediction_correct,
   output logic [COUNT_BITS-1:0] rsp_correct_total,
   output logic [COUNT_BITS-1:0] rsp_wrong_total
);

   logic                 accept;
   logic [ADDR_BITS-1:0] addr_mod;

   logic      s1_valid_ff;
   index_type s1_index_ff;
   logic      s1_taken_ff;
   logic      init_pred_ff;

   logic      rsp_valid_ff;
   logic      rsp_pred_ff;
   logic      rsp_hit_ff;
   count_type rsp_correct_ff;
   count_type rsp_wrong_ff;

   update_type upd;
   fill_type   fill;
   tally_type  tally;
   totals_type totals;
   logic       predicted;
   logic       hit;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // entry select
   assign addr_mod = req_branch_address % ADDR_BITS'(TABLE_ENTRIES);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         init_pred_ff <= INIT_PREDICTION_RESET;
      end else if (csr_valid && csr_ready) begin
         init_pred_ff <= csr_initial_prediction;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_index_ff <= addr_mod[INDEX_BITS-1:0];
         s1_taken_ff <= req_taken;
      end
   end

   // table lookup and update
   assign upd.valid  = s1_valid_ff;
   assign upd.index  = s1_index_ff;
   assign upd.taken  = s1_taken_ff;
   assign fill.en    = csr_valid && csr_ready;
   assign fill.value = csr_initial_prediction;

   bhtp_table u_table (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .fill      (fill),
      .predicted (predicted)
   );

   // running totals
   assign hit         = (predicted == s1_taken_ff);
   assign tally.valid = s1_valid_ff;
   assign tally.hit   = hit;

   bhtp_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .tally  (tally),
      .totals (totals)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_pred_ff    <= predicted;
         rsp_hit_ff     <= hit;
         rsp_correct_ff <= totals.correct;
         rsp_wrong_ff   <= totals.wrong;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_predicted_taken    = rsp_pred_ff;
   assign rsp_prediction_correct = rsp_hit_ff;
   assign rsp_correct_total      = rsp_correct_ff;
   assign rsp_wrong_total        = rsp_wrong_ff;

   // a result beat follows an occupied input register
   a_rsp_follows_s1 : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(s1_valid_ff))
      else $error("result beat without a preceding input beat");

   // a correct prediction leaves a nonzero correct total
   a_correct_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_correct_ff != '0))
      else $error("correct total zero after a correct prediction");

   // a wrong prediction leaves a nonzero wrong total
   a_wrong_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_wrong_ff != '0))
      else $error("wrong total zero after a wrong prediction");

   // the reported hit matches prediction and outcome of the same beat
   a_hit_consistent : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> (rsp_hit_ff == ($past(predicted) == $past(s1_taken_ff))))
      else $error("hit flag does not match prediction and outcome");

endmodule

### rtl/bhtp_table.sv
module bhtp_table
   import bhtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  update_type upd,
   input  fill_type   fill,
   output logic       predicted
);

   logic        pred_ff [TABLE_ENTRIES];
   history_type hist_ff [TABLE_ENTRIES];

   logic [HISTORY_BITS:0] shifted;
   history_type           hist_new;
   logic                  set_taken;
   logic                  set_not_taken;

   // read the addressed entry
   assign predicted = pred_ff[upd.index];

   // shift the outcome into the entry history
   assign shifted       = {hist_ff[upd.index], upd.taken};
   assign hist_new      = shifted[HISTORY_BITS-1:0];
   assign set_taken     = &hist_new;
   assign set_not_taken = ~|hist_new;

   // table storage, write-back of the addressed entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            pred_ff[i] <= INIT_PREDICTION_RESET;
            hist_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (upd.valid && (upd.index == index_type'(i))) begin
               hist_ff[i] <= hist_new;
            end
            if (fill.en) begin
               pred_ff[i] <= fill.value;
            end else if (upd.valid && (upd.index == index_type'(i))) begin
               if (set_taken) begin
                  pred_ff[i] <= 1'b1;
               end else if (set_not_taken) begin
                  pred_ff[i] <= 1'b0;
               end
            end
         end
      end
   end

endmodule

### rtl/bhtp_counters.sv
module bhtp_counters
   import bhtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  tally_type  tally,
   output totals_type totals
);

   count_type correct_ff, correct_in;
   count_type wrong_ff,   wrong_in;

   // saturating increments
   always_comb begin
      correct_in = correct_ff;
      wrong_in   = wrong_ff;
      if (tally.valid) begin
         if (tally.hit) begin
            if (!(&correct_ff)) correct_in = correct_ff + count_type'(1);
         end else begin
            if (!(&wrong_ff)) wrong_in = wrong_ff + count_type'(1);
         end
      end
   end

   // totals including the current beat
   assign totals.correct = correct_in;
   assign totals.wrong   = wrong_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         correct_ff <= '0;
         wrong_ff   <= '0;
      end else begin
         correct_ff <= correct_in;
         wrong_ff   <= wrong_in;
      end
   end

endmodule

### tb/bht_prediction_monitor.sv
`timescale 1ns / 100ps

module bht_prediction_monitor
   import bhtp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [ADDR_BITS-1:0]  req_branch_address,
   input  logic                  req_taken,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic                  csr_initial_prediction,
   input  logic                  rsp_valid,
   input  logic                  rsp_predicted_taken,
   input  logic                  rsp_prediction_correct,
   input  logic [COUNT_BITS-1:0] rsp_correct_total,
   input  logic [COUNT_BITS-1:0] rsp_wrong_total,
   output int                    mismatches,
   output int                    outstanding
);

   // what the table should report for one resolved branch
   typedef struct {
      logic      predicted;
      logic      correct;
      count_type correct_total;
      count_type wrong_total;
   } branch_verdict_type;

   // shadow copy of the table, the totals and the register
   logic               shadow_prediction [TABLE_ENTRIES];
   history_type        shadow_history [TABLE_ENTRIES];
   count_type          right_count;
   count_type          miss_count;
   logic               shadow_init_prediction;
   branch_verdict_type pending_verdicts [$];

   // load every prediction bit with one value
   function automatic void fill_predictions(input logic value);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         shadow_prediction[i] = value;
      end
   endfunction

   // look up the stored guess, bump a total, shift the outcome into the history, set the guess on all ones or all zeros
   function automatic branch_verdict_type resolve_branch(input logic [ADDR_BITS-1:0] address,
                                                         input logic actual);
      branch_verdict_type verdict;
      int                 slot;
      history_type        updated;
      slot = address % TABLE_ENTRIES;
      verdict.predicted = shadow_prediction[slot];
      verdict.correct = (shadow_prediction[slot] == actual);
      if (verdict.correct) begin
         if (right_count != '1) right_count = right_count + 1'b1;
      end else begin
         if (miss_count != '1) miss_count = miss_count + 1'b1;
      end
      verdict.correct_total = right_count;
      verdict.wrong_total = miss_count;
      updated = history_type'({shadow_history[slot], actual});
      shadow_history[slot] = updated;
      if (updated == '1) shadow_prediction[slot] = 1'b1;
      else if (updated == '0) shadow_prediction[slot] = 1'b0;
      return verdict;
   endfunction

   task automatic compare_field(input string label, input logic [COUNT_BITS-1:0] want,
                                input logic [COUNT_BITS-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      branch_verdict_type oldest;
      if (reset) begin
         shadow_init_prediction = INIT_PREDICTION_RESET;
         fill_predictions(INIT_PREDICTION_RESET);
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_history[i] = '0;
         end
         right_count = '0;
         miss_count = '0;
         pending_verdicts.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_valid) begin
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected, actual %0h %0h %0h %0h",
                        $time, rsp_predicted_taken, rsp_prediction_correct,
                        rsp_correct_total, rsp_wrong_total);
            end else begin
               oldest = pending_verdicts.pop_front();
               compare_field("predicted_taken", oldest.predicted, rsp_predicted_taken);
               compare_field("prediction_correct", oldest.correct, rsp_prediction_correct);
               compare_field("correct_total", oldest.correct_total, rsp_correct_total);
               compare_field("wrong_total", oldest.wrong_total, rsp_wrong_total);
            end
         end
         // register write reloads every prediction bit
         if (csr_valid && csr_ready) begin
            shadow_init_prediction = csr_initial_prediction;
            fill_predictions(shadow_init_prediction);
         end
         // accepted branch
         if (start && !busy) begin
            pending_verdicts.push_back(resolve_branch(req_branch_address, req_taken));
         end
      end
      outstanding <= pending_verdicts.size();
   end

endmodule

### tb/branch_history_table_predictor_unit_test.sv
`timescale 1ns / 100ps

module branch_history_table_predictor_unit_test;
   import bhtp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_BEATS = 310;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ADDR_BITS-1:0]  req_branch_address;
   logic                  req_taken;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_initial_prediction;
   logic                  rsp_valid;
   logic                  rsp_predicted_taken;
   logic                  rsp_prediction_correct;
   logic [COUNT_BITS-1:0] rsp_correct_total;
   logic [COUNT_BITS-1:0] rsp_wrong_total;
   int                    mismatches;
   int                    outstanding;
   int                    quiet_cycles;

   branch_history_table_predictor_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_branch_address     (req_branch_address),
      .req_taken              (req_taken),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_initial_prediction (csr_initial_prediction),
      .rsp_valid              (rsp_valid),
      .rsp_predicted_taken    (rsp_predicted_taken),
      .rsp_prediction_correct (rsp_prediction_correct),
      .rsp_correct_total      (rsp_correct_total),
      .rsp_wrong_total        (rsp_wrong_total)
   );

   bht_prediction_monitor prediction_watch (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_branch_address     (req_branch_address),
      .req_taken              (req_taken),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_initial_prediction (csr_initial_prediction),
      .rsp_valid              (rsp_valid),
      .rsp_predicted_taken    (rsp_predicted_taken),
      .rsp_prediction_correct (rsp_prediction_correct),
      .rsp_correct_total      (rsp_correct_total),
      .rsp_wrong_total        (rsp_wrong_total),
      .mismatches             (mismatches),
      .outstanding            (outstanding)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one branch beat, after random idle cycles
   task automatic send_branch(input logic [ADDR_BITS-1:0] address, input logic outcome,
                              input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_branch_address <= address;
      req_taken <= outcome;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // let every result drain out of the pipe
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only once the block is idle
   task automatic write_initial_prediction(input logic value);
      drain_results();
      csr_valid <= 1'b1;
      csr_initial_prediction <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random beats: mostly runs of biased outcomes on a few hot entries, the rest noise
   task automatic random_branches(input int count, input int idle_pct);
      logic [ADDR_BITS-1:0] address;
      int                   bias;
      bit                   burst;
      bias = 90;
      burst = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            case ($urandom_range(2))
               0: bias = 90;
               1: bias = 10;
               default: bias = 50;
            endcase
         end
         if (i % 40 == 0) burst = ($urandom_range(3) == 0);
         address = $urandom();
         if ($urandom_range(99) < 60) begin
            address = address - (address % TABLE_ENTRIES) + $urandom_range(7);
         end
         send_branch(address, ($urandom_range(99) < bias), burst ? 0 : idle_pct);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_branch_address = '0;
      req_taken = 1'b0;
      csr_valid = 1'b0;
      csr_initial_prediction = 1'b0;
      quiet_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: address extremes, aliasing onto one entry, both history flips
      send_branch(32'h0000_0000, 1'b1, 0);
      send_branch(32'hFFFF_FFFF, 1'b0, 0);
      send_branch(32'h0000_0005, 1'b0, 0);
      send_branch(32'h0000_0025, 1'b0, 0);
      send_branch(32'hFFFF_FFE5, 1'b0, 0);
      send_branch(32'h8000_0005, 1'b0, 0);
      send_branch(32'h0000_0005, 1'b0, 0);
      send_branch(32'h0000_0045, 1'b1, 0);
      send_branch(32'h7FFF_FFE5, 1'b1, 0);
      send_branch(32'h0000_0005, 1'b1, 0);
      send_branch(32'hAAAA_AAA5, 1'b1, 0);
      send_branch(32'h5555_5545, 1'b1, 0);
      send_branch(32'h8000_0000, 1'b0, 0);
      send_branch(32'h7FFF_FFFF, 1'b1, 0);
      send_branch(32'hAAAA_AAAA, 1'b0, 0);
      send_branch(32'h5555_5555, 1'b1, 0);
      write_initial_prediction(1'b0);
      send_branch(32'h0000_0000, 1'b0, 0);
      send_branch(32'h0000_0005, 1'b1, 0);
      send_branch(32'hFFFF_FFFF, 1'b1, 0);

      // random phases over several register settings
      random_branches(PHASE_BEATS / 2, 13);
      write_initial_prediction(1'b1);
      random_branches(PHASE_BEATS / 2, 13);
      write_initial_prediction(1'b0);
      random_branches(PHASE_BEATS, 75);
      write_initial_prediction(1'b1);
      random_branches(PHASE_BEATS / 2, 0);
      write_initial_prediction(1'b0);
      random_branches(PHASE_BEATS / 2, 0);

      drain_results();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
